// File: rtl/core/hpack_hfp_pkg.sv
// Shared types, codes and constants of the HPACK header field parser.
// Used by hpack_hfp_core and hpack_header_field_parser_top; depends on nothing.

package hpack_hfp_pkg;

    // Width of the number field and of the limit register.
    localparam int unsigned NUM_W = 20;
    // Integer accumulator width. It is one bit wider than any limit, so a
    // saturated value always lies above the limit.
    localparam int unsigned ACC_W = NUM_W + 1;
    localparam int unsigned LENGTH_BITS_DEF = 20;
    localparam logic [NUM_W-1:0] MAX_INTEGER_RESET = 20'd65535;

    typedef enum logic [2:0] {
        EV_DONE  = 3'd0,
        EV_LEN   = 3'd1,
        EV_BYTE  = 3'd2,
        EV_ERR   = 3'd3,
        EV_BLOCK = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        KIND_INDEXED     = 3'd0,
        KIND_INCREMENTAL = 3'd1,
        KIND_WITHOUT_IDX = 3'd2,
        KIND_NEVER_IDX   = 3'd3,
        KIND_SIZE_UPDATE = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_INDEX = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_EOS        = 3'd3,
        ST_TRUNCATED  = 3'd4
    } status_t;

    typedef enum logic [5:0] {
        PH_FIRST     = 6'b000001,
        PH_IDX_CONT  = 6'b000010,
        PH_LEN_FIRST = 6'b000100,
        PH_LEN_CONT  = 6'b001000,
        PH_STR       = 6'b010000,
        PH_DRAIN     = 6'b100000
    } phase_t;

    typedef struct packed {
        event_t           ev;
        kind_t            kind;
        logic [NUM_W-1:0] number;
        logic [7:0]       sbyte;
        logic             is_name;
        logic             huff;
        status_t          status;
        logic             last;
    } result_t;

    function automatic result_t mk_result(event_t ev, logic [NUM_W-1:0] number,
                                          logic [7:0] sbyte, logic is_name,
                                          logic huff, status_t status);
        result_t r;
        r.ev      = ev;
        r.kind    = KIND_INDEXED;
        r.number  = number;
        r.sbyte   = sbyte;
        r.is_name = is_name;
        r.huff    = huff;
        r.status  = status;
        r.last    = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/core/hpack_hfp_core.sv
// Per-byte parsing state and result generation of the HPACK header field parser.
// Depends on hpack_hfp_pkg; instantiated by hpack_header_field_parser_top.

module hpack_hfp_core #(
    parameter int unsigned LENGTH_BITS = hpack_hfp_pkg::LENGTH_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    fire,
    input  logic [7:0]                              data_byte,
    input  logic                                    blk_end,
    input  logic [hpack_hfp_pkg::NUM_W-1:0]         max_integer,
    output hpack_hfp_pkg::result_t                  res0,
    output hpack_hfp_pkg::result_t                  res1,
    output logic [1:0]                              res_cnt
);

    localparam int unsigned NUM_W = hpack_hfp_pkg::NUM_W;
    localparam int unsigned ACC_W = hpack_hfp_pkg::ACC_W;
    localparam int unsigned CNT_W = (LENGTH_BITS < NUM_W) ? LENGTH_BITS : NUM_W;
    localparam logic [NUM_W-1:0] CNT_MAX = NUM_W'((64'd1 << CNT_W) - 64'd1);

    hpack_hfp_pkg::phase_t phase_reg, phase_next;
    hpack_hfp_pkg::kind_t  kind_reg, kind_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [4:0]            shift_reg, shift_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      held_reg, held_next;
    logic                  name_reg, name_next;
    logic                  huff_reg, huff_next;
    logic [23:0]           recent_reg, recent_next;
    logic [1:0]            fill_reg, fill_next;

    logic [NUM_W-1:0]       limit;
    hpack_hfp_pkg::result_t rs [2];
    logic [1:0]             cnt_c;

    assign limit = (max_integer > CNT_MAX) ? CNT_MAX : max_integer;

    always_comb begin
        logic [ACC_W+6:0] sum_w;
        logic [ACC_W-1:0] sum_v;
        logic [ACC_W-1:0] int_v;
        logic             int_fire;
        logic             idx_path;
        logic             err_now;
        logic [6:0]       pmax;
        logic [6:0]       pfield;
        logic [5:0]       shift_sum;
        logic [CNT_W-1:0] rem_dec;

        phase_next  = phase_reg;
        kind_next   = kind_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        held_next   = held_reg;
        name_next   = name_reg;
        huff_next   = huff_reg;
        recent_next = recent_reg;
        fill_next   = fill_reg;

        rs[0]    = hpack_hfp_pkg::mk_result(hpack_hfp_pkg::EV_DONE, '0, '0, 1'b0, 1'b0,
                                            hpack_hfp_pkg::ST_OK);
        rs[1]    = rs[0];
        cnt_c    = 2'd0;
        int_fire = 1'b0;
        idx_path = 1'b0;
        err_now  = 1'b0;
        int_v    = '0;
        pmax     = 7'h7f;
        pfield   = '0;

        // Continuation byte of a prefix integer, saturating once out of range.
        shift_sum = {1'b0, shift_reg} + 6'd7;
        if (shift_reg >= 5'(ACC_W)) begin
            sum_w = '0;
            sum_v = (data_byte[6:0] != 7'd0) ? '1 : acc_reg;
        end else begin
            sum_w = {7'd0, acc_reg} + ((ACC_W+7)'(data_byte[6:0]) << shift_reg);
            sum_v = (|sum_w[ACC_W+6:ACC_W]) ? '1 : sum_w[ACC_W-1:0];
        end
        rem_dec = (rem_reg != '0) ? rem_reg - CNT_W'(1) : rem_reg;

        if (phase_reg == hpack_hfp_pkg::PH_DRAIN) begin
            if (blk_end) begin
                rs[0] = hpack_hfp_pkg::mk_result(hpack_hfp_pkg::EV_BLOCK, '0, '0, 1'b0,
                                                 1'b0, hpack_hfp_pkg::ST_OK);
                cnt_c = 2'd1;
                phase_next = hpack_hfp_pkg::PH_FIRST;
            end
        end else begin
            unique case (phase_reg)
                hpack_hfp_pkg::PH_IDX_CONT, hpack_hfp_pkg::PH_LEN_CONT: begin
                    idx_path = (phase_reg == hpack_hfp_pkg::PH_IDX_CONT);
                    acc_next = sum_v;
                    if (data_byte[7]) begin
                        shift_next = (shift_sum > 6'd31) ? 5'd31 : shift_sum[4:0];
                    end else begin
                        int_fire = 1'b1;
                        int_v    = sum_v;
                    end
                end
                hpack_hfp_pkg::PH_LEN_FIRST: begin
                    huff_next = data_byte[7];
                    if (data_byte[6:0] != 7'h7f) begin
                        int_fire = 1'b1;
                        int_v    = ACC_W'(data_byte[6:0]);
                    end else begin
                        acc_next   = ACC_W'(7'h7f);
                        shift_next = 5'd0;
                        phase_next = hpack_hfp_pkg::PH_LEN_CONT;
                    end
                end
                hpack_hfp_pkg::PH_STR: begin
                    // Four bytes of all ones but the top two bits: the EOS code.
                    if (fill_reg == 2'd3 && recent_reg == 24'h3fffff && data_byte == 8'hff) begin
                        err_now    = 1'b1;
                        phase_next = hpack_hfp_pkg::PH_DRAIN;
                        rs[cnt_c[0]] = hpack_hfp_pkg::mk_result(hpack_hfp_pkg::EV_ERR, '0,
                                           '0, 1'b0, 1'b0, hpack_hfp_pkg::ST_EOS);
                        cnt_c = cnt_c + 2'd1;
                    end else begin
                        recent_next = {recent_reg[15:0], data_byte};
                        if (fill_reg != 2'd3) begin
                            fill_next = fill_reg + 2'd1;
                        end
                        rem_next = rem_dec;
                        rs[cnt_c[0]] = hpack_hfp_pkg::mk_result(hpack_hfp_pkg::EV_BYTE,
                                           NUM_W'(rem_dec), data_byte, name_reg, huff_reg,
                                           hpack_hfp_pkg::ST_OK);
                        cnt_c = cnt_c + 2'd1;
                        if (rem_dec == '0) begin
                            if (name_reg) begin
                                name_next  = 1'b0;
                                phase_next = hpack_hfp_pkg::PH_LEN_FIRST;
                            end else begin
                                phase_next = hpack_hfp_pkg::PH_FIRST;
                                rs[cnt_c[0]] = hpack_hfp_pkg::mk_result(
                                                   hpack_hfp_pkg::EV_DONE, NUM_W'(held_reg),
                                                   '0, 1'b0, 1'b0, hpack_hfp_pkg::ST_OK);
                                cnt_c = cnt_c + 2'd1;
                            end
                        end
                    end
                end
                default: begin
                    // First byte of a representation: the leading bits give the kind.
                    idx_path   = 1'b1;
                    phase_next = hpack_hfp_pkg::PH_FIRST;
                    priority if (data_byte[7]) begin
                        kind_next = hpack_hfp_pkg::KIND_INDEXED;
                        pmax      = 7'h7f;
                    end else if (data_byte[6]) begin
                        kind_next = hpack_hfp_pkg::KIND_INCREMENTAL;
                        pmax      = 7'h3f;
                    end else if (data_byte[5]) begin
                        kind_next = hpack_hfp_pkg::KIND_SIZE_UPDATE;
                        pmax      = 7'h1f;
                    end else if (data_byte[4]) begin
                        kind_next = hpack_hfp_pkg::KIND_NEVER_IDX;
                        pmax      = 7'h0f;
                    end else begin
                        kind_next = hpack_hfp_pkg::KIND_WITHOUT_IDX;
                        pmax      = 7'h0f;
                    end
                    pfield = data_byte[6:0] & pmax;
                    if (pfield < pmax) begin
                        int_fire = 1'b1;
                        int_v    = ACC_W'(pfield);
                    end else begin
                        acc_next   = ACC_W'(pmax);
                        shift_next = 5'd0;
                        phase_next = hpack_hfp_pkg::PH_IDX_CONT;
                    end
                end
            endcase

            if (int_fire) begin
                if (int_v > ACC_W'(limit)) begin
                    err_now    = 1'b1;
                    phase_next = hpack_hfp_pkg::PH_DRAIN;
                    rs[cnt_c[0]] = hpack_hfp_pkg::mk_result(hpack_hfp_pkg::EV_ERR, '0, '0,
                                       1'b0, 1'b0, hpack_hfp_pkg::ST_TOO_LARGE);
                    cnt_c = cnt_c + 2'd1;
                end else if (idx_path) begin
                    if (kind_next == hpack_hfp_pkg::KIND_INDEXED && int_v == '0) begin
                        err_now    = 1'b1;
                        phase_next = hpack_hfp_pkg::PH_DRAIN;
                        rs[cnt_c[0]] = hpack_hfp_pkg::mk_result(hpack_hfp_pkg::EV_ERR, '0,
                                           '0, 1'b0, 1'b0, hpack_hfp_pkg::ST_ZERO_INDEX);
                        cnt_c = cnt_c + 2'd1;
                    end else if (kind_next == hpack_hfp_pkg::KIND_INDEXED ||
                                 kind_next == hpack_hfp_pkg::KIND_SIZE_UPDATE) begin
                        phase_next = hpack_hfp_pkg::PH_FIRST;
                        rs[cnt_c[0]] = hpack_hfp_pkg::mk_result(hpack_hfp_pkg::EV_DONE,
                                           NUM_W'(int_v), '0, 1'b0, 1'b0,
                                           hpack_hfp_pkg::ST_OK);
                        cnt_c = cnt_c + 2'd1;
                    end else begin
                        // A literal: index zero means a new name string follows.
                        held_next  = CNT_W'(int_v);
                        name_next  = (int_v == '0);
                        phase_next = hpack_hfp_pkg::PH_LEN_FIRST;
                    end
                end else if (int_v == '0) begin
                    if (name_reg) begin
                        name_next  = 1'b0;
                        phase_next = hpack_hfp_pkg::PH_LEN_FIRST;
                    end else begin
                        phase_next = hpack_hfp_pkg::PH_FIRST;
                        rs[cnt_c[0]] = hpack_hfp_pkg::mk_result(hpack_hfp_pkg::EV_DONE,
                                           NUM_W'(held_reg), '0, 1'b0, 1'b0,
                                           hpack_hfp_pkg::ST_OK);
                        cnt_c = cnt_c + 2'd1;
                    end
                end else begin
                    rs[cnt_c[0]] = hpack_hfp_pkg::mk_result(hpack_hfp_pkg::EV_LEN,
                                       NUM_W'(int_v), '0, name_reg, huff_next,
                                       hpack_hfp_pkg::ST_OK);
                    cnt_c       = cnt_c + 2'd1;
                    rem_next    = CNT_W'(int_v);
                    recent_next = '0;
                    fill_next   = 2'd0;
                    phase_next  = hpack_hfp_pkg::PH_STR;
                end
            end

            if (blk_end) begin
                if (err_now) begin
                    phase_next = hpack_hfp_pkg::PH_FIRST;
                end else if (phase_next == hpack_hfp_pkg::PH_FIRST) begin
                    // A representation finished on the final byte reports as block done.
                    if (cnt_c == 2'd1) begin
                        rs[0].ev = hpack_hfp_pkg::EV_BLOCK;
                    end else if (cnt_c == 2'd2) begin
                        rs[1].ev = hpack_hfp_pkg::EV_BLOCK;
                    end
                end else begin
                    rs[cnt_c[0]] = hpack_hfp_pkg::mk_result(hpack_hfp_pkg::EV_ERR, '0, '0,
                                       1'b0, 1'b0, hpack_hfp_pkg::ST_TRUNCATED);
                    cnt_c      = cnt_c + 2'd1;
                    phase_next = hpack_hfp_pkg::PH_FIRST;
                end
            end
        end

        rs[0].kind = kind_next;
        rs[1].kind = kind_next;
        if (cnt_c == 2'd1) begin
            rs[0].last = 1'b1;
        end else if (cnt_c == 2'd2) begin
            rs[1].last = 1'b1;
        end
    end

    assign res0    = rs[0];
    assign res1    = rs[1];
    assign res_cnt = cnt_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= hpack_hfp_pkg::PH_FIRST;
            kind_reg   <= hpack_hfp_pkg::KIND_INDEXED;
            acc_reg    <= '0;
            shift_reg  <= '0;
            rem_reg    <= '0;
            held_reg   <= '0;
            name_reg   <= 1'b0;
            huff_reg   <= 1'b0;
            recent_reg <= '0;
            fill_reg   <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            acc_reg    <= acc_next;
            shift_reg  <= shift_next;
            rem_reg    <= rem_next;
            held_reg   <= held_next;
            name_reg   <= name_next;
            huff_reg   <= huff_next;
            recent_reg <= recent_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// File: rtl/core/hpack_header_field_parser_top.sv
// HPACK header field parser: the top level with input register, limit
// register and result buffer. Depends on hpack_hfp_pkg and hpack_hfp_core.
//
// Usage: header block bytes enter on the s_ channel, one byte per item, with
// s_block_end marking the last byte of a block. Each byte yields zero, one or
// two result items on the m_ channel; m_last_result marks the last result
// caused by a byte. The limit on decoded integers is written through the cfg
// channel, which is always ready; write it only while the parser is idle.
// A byte accepted on the s_ channel goes through the input register and the
// per-byte update into the result buffer, whose head drives the m_ ports.
// Both take one byte every cycle, as long as the result buffer drains; a byte
// with two results holds the buffer until the first of them is taken.
// While the receiver stalls, the result buffer holds and one more byte is
// still taken into the input register before s_ready falls.
// Reset (synchronous, aresetn low) empties both registers, sets the limit
// to 65535 and returns the parser to the start of a header block.

module hpack_header_field_parser_top #(
    parameter int unsigned LENGTH_BITS = hpack_hfp_pkg::LENGTH_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_in,
    input  logic                              s_block_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_event_res,
    output logic [2:0]                        m_field_kind,
    output logic [hpack_hfp_pkg::NUM_W-1:0]   m_number,
    output logic [7:0]                        m_string_byte,
    output logic                              m_is_name,
    output logic                              m_huffman_flag,
    output logic [2:0]                        m_status,
    output logic                              m_last_result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hpack_hfp_pkg::NUM_W-1:0]   cfg_data
);

    logic                            in_valid_reg;
    logic [7:0]                      in_data_reg;
    logic                            in_end_reg;
    logic [hpack_hfp_pkg::NUM_W-1:0] max_integer_reg;

    hpack_hfp_pkg::result_t res0_reg, res1_reg;
    logic [1:0]             out_cnt_reg;

    hpack_hfp_pkg::result_t core_res0, core_res1;
    logic [1:0]             core_cnt;
    logic                   fire;
    logic                   pop;
    logic                   s_accept;

    assign m_valid   = (out_cnt_reg != 2'd0);
    assign pop       = m_valid && m_ready;
    // The core may run when the buffer is empty or gives up its last result now.
    assign fire      = in_valid_reg &&
                       (out_cnt_reg == 2'd0 || (out_cnt_reg == 2'd1 && m_ready));
    assign s_ready   = !in_valid_reg || fire;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    hpack_hfp_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .data_byte   (in_data_reg),
        .blk_end     (in_end_reg),
        .max_integer (max_integer_reg),
        .res0        (core_res0),
        .res1        (core_res1),
        .res_cnt     (core_cnt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_data_in;
            in_end_reg  <= s_block_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_integer_reg <= hpack_hfp_pkg::MAX_INTEGER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_integer_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= 2'd0;
        end else if (fire) begin
            out_cnt_reg <= core_cnt;
        end else if (pop) begin
            out_cnt_reg <= out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res0_reg <= core_res0;
            res1_reg <= core_res1;
        end else if (pop) begin
            res0_reg <= res1_reg;
        end
    end

    assign m_event_res    = res0_reg.ev;
    assign m_field_kind   = res0_reg.kind;
    assign m_number       = res0_reg.number;
    assign m_string_byte  = res0_reg.sbyte;
    assign m_is_name      = res0_reg.is_name;
    assign m_huffman_flag = res0_reg.huff;
    assign m_status       = res0_reg.status;
    assign m_last_result  = res0_reg.last;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_last_single: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg == 2'd1 |-> res0_reg.last)
        else $error("single buffered result is not marked last");

    a_last_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg == 2'd2 |-> (!res0_reg.last && res1_reg.last))
        else $error("buffered result pair has wrong last marks");

    a_err_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((res0_reg.ev == hpack_hfp_pkg::EV_ERR) ==
                     (res0_reg.status != hpack_hfp_pkg::ST_OK)))
        else $error("error status does not match event");
`endif

endmodule
